// File: design/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types and constants of the conversation counter.
// ----------------------------------------------------------------------------
package bcc_pkg;

	localparam int KEY_W   = 48;
	localparam int BYTES_W = 16;
	localparam int IDX_W   = 6;
	localparam int OUT_CW  = 32;
	localparam int NUM_TBL = 3;

	localparam logic       FUNC_RECORD = 1'b0;
	localparam logic       FUNC_READ   = 1'b1;
	localparam logic [1:0] TBL_MAC     = 2'd0;
	localparam logic [1:0] TBL_IP      = 2'd1;
	localparam logic [1:0] TBL_PORT    = 2'd2;

	// update command broadcast to every cell of one table
	typedef struct packed {
		logic upd_fwd;
		logic upd_rev;
		logic upd_new;
	} bcc_ctrl_t;

endpackage

// File: design/bcc_cell.sv
// ----------------------------------------------------------------------------
// bcc_cell
// One conversation slot: keys, forward/reverse counters, and one stage of the
// registered hit and readout chain.
// ----------------------------------------------------------------------------
module bcc_cell import bcc_pkg::*; #(
	parameter int IDX    = 0,
	parameter int CNT_W  = 32,
	parameter int FILL_W = 7,
	parameter int RD_W   = 1 + 2 * KEY_W + 4 * CNT_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [KEY_W-1:0]  key_a,
	input  logic [KEY_W-1:0]  key_b,
	input  logic [BYTES_W-1:0] bytes,
	input  logic [IDX_W-1:0]  rd_idx,
	input  bcc_ctrl_t         ctrl,
	input  logic [FILL_W-1:0] fill,
	input  logic              f_in,
	input  logic              r_in,
	input  logic [RD_W-1:0]   rd_in,
	output logic              f_out,
	output logic              r_out,
	output logic [RD_W-1:0]   rd_out
);

	localparam int SUM_W = ((CNT_W > BYTES_W) ? CNT_W : BYTES_W) + 1;

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
			input logic [BYTES_W-1:0] v);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(c) + SUM_W'(v);
		if (sum > SUM_W'({CNT_W{1'b1}}))
			return {CNT_W{1'b1}};
		return CNT_W'(sum);
	endfunction

	logic             used_q;
	logic [KEY_W-1:0] ka_q, kb_q;
	logic [CNT_W-1:0] fp_q, fb_q, rp_q, rb_q;
	logic             f_q, r_q;
	logic [RD_W-1:0]  rd_q;
	logic             hit_f, hit_r, is_alloc, is_rd;

	assign hit_f    = used_q && ka_q == key_a && kb_q == key_b;
	assign hit_r    = used_q && ka_q == key_b && kb_q == key_a;
	assign is_alloc = ctrl.upd_new && (32'(fill) == 32'(IDX));
	assign is_rd    = (32'(rd_idx) == 32'(IDX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (is_alloc) begin
			used_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (is_alloc) begin
			ka_q <= key_a;
			kb_q <= key_b;
			fp_q <= sat_add('0, BYTES_W'(1));
			fb_q <= sat_add('0, bytes);
			rp_q <= '0;
			rb_q <= '0;
		end else if (ctrl.upd_fwd && hit_f) begin
			fp_q <= sat_add(fp_q, BYTES_W'(1));
			fb_q <= sat_add(fb_q, bytes);
		end else if (ctrl.upd_rev && hit_r) begin
			rp_q <= sat_add(rp_q, BYTES_W'(1));
			rb_q <= sat_add(rb_q, bytes);
		end
	end

	// chain stage: hit flags OR in, selected slot replaces readout data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_q  <= 1'b0;
			r_q  <= 1'b0;
			rd_q <= '0;
		end else begin
			f_q <= f_in | hit_f;
			r_q <= r_in | hit_r;
			if (is_rd) begin
				rd_q <= used_q ? {1'b1, ka_q, kb_q, fp_q, fb_q, rp_q, rb_q} : '0;
			end else begin
				rd_q <= rd_in;
			end
		end
	end

	assign f_out  = f_q;
	assign r_out  = r_q;
	assign rd_out = rd_q;

endmodule

// File: design/bcc_table.sv
// ----------------------------------------------------------------------------
// bcc_table
// One conversation table: a row of slot cells, fill level and overflow flag.
// ----------------------------------------------------------------------------
module bcc_table import bcc_pkg::*; #(
	parameter int ENTRIES = 64,
	parameter int CNT_W   = 32,
	parameter int RD_W    = 1 + 2 * KEY_W + 4 * CNT_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [KEY_W-1:0]   key_a,
	input  logic [KEY_W-1:0]   key_b,
	input  logic [BYTES_W-1:0] bytes,
	input  logic [IDX_W-1:0]   rd_idx,
	input  logic               apply,
	output logic [RD_W-1:0]    rd_data,
	output logic               ovf
);

	localparam int FILL_W = $clog2(ENTRIES + 1);

	logic [FILL_W-1:0] fill_q;
	logic              ovf_q;
	logic [ENTRIES:0]  f_chain, r_chain;
	logic [RD_W-1:0]   rd_chain [ENTRIES+1];
	logic              full, any_f, any_r;
	bcc_ctrl_t         ctrl;

	assign f_chain[0]  = 1'b0;
	assign r_chain[0]  = 1'b0;
	assign rd_chain[0] = '0;
	assign any_f       = f_chain[ENTRIES];
	assign any_r       = r_chain[ENTRIES];
	assign full        = (fill_q == FILL_W'(ENTRIES));

	assign ctrl.upd_fwd = apply && any_f;
	assign ctrl.upd_rev = apply && !any_f && any_r;
	assign ctrl.upd_new = apply && !any_f && !any_r && !full;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		bcc_cell #(
			.IDX(i), .CNT_W(CNT_W), .FILL_W(FILL_W), .RD_W(RD_W)
		) u_cell (
			.clk(clk), .arst_n(arst_n),
			.key_a(key_a), .key_b(key_b), .bytes(bytes), .rd_idx(rd_idx),
			.ctrl(ctrl), .fill(fill_q),
			.f_in(f_chain[i]), .r_in(r_chain[i]), .rd_in(rd_chain[i]),
			.f_out(f_chain[i+1]), .r_out(r_chain[i+1]), .rd_out(rd_chain[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			ovf_q  <= 1'b0;
		end else if (apply && !any_f && !any_r) begin
			if (full) begin
				ovf_q <= 1'b1;
			end else begin
				fill_q <= fill_q + FILL_W'(1);
			end
		end
	end

	assign rd_data = rd_chain[ENTRIES];
	assign ovf     = ovf_q;

endmodule

// File: design/bidirectional_conversation_counter_top.sv
// ----------------------------------------------------------------------------
// bidirectional_conversation_counter_top
// Three conversation tables (MAC, IPv4, TCP port pairs) with per-direction
// saturating packet and byte counters, plus slot readout.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_stall  | func, keys, length, table/slot
// out     | output    | out_valid / out_stall| entry_valid, end_a/b, counters
//
// After acceptance the captured keys sweep the registered hit/readout chain
// of each table in ST_SWEEP, then ST_APPLY applies the update or loads the
// result register. The tables are updated in parallel, the IP table only for
// IPv4 and the port table only for IPv4 TCP. Reset clears slot used bits,
// fill levels and overflow flags at once; no clearing pass. A held result
// only blocks a later read in ST_APPLY, never a record transaction.
// ----------------------------------------------------------------------------
module bidirectional_conversation_counter_top import bcc_pkg::*; #(
	parameter int ENTRIES_PER_TABLE = 64,
	parameter int COUNTER_BITS      = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               func,
	input  logic [47:0]        src_mac,
	input  logic [47:0]        dst_mac,
	input  logic               is_ipv4,
	input  logic [31:0]        src_ip,
	input  logic [31:0]        dst_ip,
	input  logic               is_tcp,
	input  logic [15:0]        src_port,
	input  logic [15:0]        dst_port,
	input  logic [15:0]        captured_length,
	input  logic [1:0]         table_select,
	input  logic [5:0]         entry_index,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               entry_valid,
	output logic [47:0]        end_a,
	output logic [47:0]        end_b,
	output logic [31:0]        a_to_b_packets,
	output logic [31:0]        a_to_b_bytes,
	output logic [31:0]        b_to_a_packets,
	output logic [31:0]        b_to_a_bytes,
	output logic               table_overflowed
);

	localparam int RD_W  = 1 + 2 * KEY_W + 4 * COUNTER_BITS;
	localparam int CNT_W = (ENTRIES_PER_TABLE > 1) ? $clog2(ENTRIES_PER_TABLE) : 1;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SWEEP = 3'b010,
		ST_APPLY = 3'b100
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;

	// captured transaction
	logic               func_q, ipv4_q, tcp_q;
	logic [47:0]        smac_q, dmac_q;
	logic [31:0]        sip_q, dip_q;
	logic [15:0]        sport_q, dport_q, len_q;
	logic [1:0]         tsel_q;
	logic [IDX_W-1:0]   idx_q;

	logic [RD_W-1:0]    rd_data [NUM_TBL];
	logic [NUM_TBL-1:0] ovf, apply;
	logic               accept, do_apply, out_free;
	logic [RD_W-1:0]    sel_rd;
	logic               sel_ovf;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid || !out_stall;
	// a read finishes only when the result register can take it
	assign do_apply = (state_q == ST_APPLY) && (func_q == FUNC_RECORD || out_free);

	assign apply[0] = do_apply && func_q == FUNC_RECORD;
	assign apply[1] = apply[0] && ipv4_q;
	assign apply[2] = apply[1] && tcp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept) state_q <= ST_SWEEP;
				end
				ST_SWEEP: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(ENTRIES_PER_TABLE - 1)) state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					if (do_apply) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= func;
			smac_q  <= src_mac;
			dmac_q  <= dst_mac;
			ipv4_q  <= is_ipv4;
			sip_q   <= src_ip;
			dip_q   <= dst_ip;
			tcp_q   <= is_tcp;
			sport_q <= src_port;
			dport_q <= dst_port;
			len_q   <= captured_length;
			tsel_q  <= table_select;
			idx_q   <= entry_index;
		end
	end

	bcc_table #(.ENTRIES(ENTRIES_PER_TABLE), .CNT_W(COUNTER_BITS), .RD_W(RD_W)) u_mac (
		.clk(clk), .arst_n(arst_n), .key_a(smac_q), .key_b(dmac_q), .bytes(len_q),
		.rd_idx(idx_q), .apply(apply[0]), .rd_data(rd_data[0]), .ovf(ovf[0])
	);

	bcc_table #(.ENTRIES(ENTRIES_PER_TABLE), .CNT_W(COUNTER_BITS), .RD_W(RD_W)) u_ip (
		.clk(clk), .arst_n(arst_n), .key_a(KEY_W'(sip_q)), .key_b(KEY_W'(dip_q)),
		.bytes(len_q), .rd_idx(idx_q), .apply(apply[1]), .rd_data(rd_data[1]),
		.ovf(ovf[1])
	);

	bcc_table #(.ENTRIES(ENTRIES_PER_TABLE), .CNT_W(COUNTER_BITS), .RD_W(RD_W)) u_port (
		.clk(clk), .arst_n(arst_n), .key_a(KEY_W'(sport_q)), .key_b(KEY_W'(dport_q)),
		.bytes(len_q), .rd_idx(idx_q), .apply(apply[2]), .rd_data(rd_data[2]),
		.ovf(ovf[2])
	);

	// table select; the unused code reads as all zero
	always_comb begin
		unique case (tsel_q)
			TBL_MAC: begin
				sel_rd  = rd_data[0];
				sel_ovf = ovf[0];
			end
			TBL_IP: begin
				sel_rd  = rd_data[1];
				sel_ovf = ovf[1];
			end
			TBL_PORT: begin
				sel_rd  = rd_data[2];
				sel_ovf = ovf[2];
			end
			default: begin
				sel_rd  = '0;
				sel_ovf = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (do_apply && func_q == FUNC_READ) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	// result register; counters narrowed or widened to the 32-bit outputs
	always_ff @(posedge clk) begin
		if (do_apply && func_q == FUNC_READ) begin
			entry_valid      <= sel_rd[RD_W-1];
			end_a            <= sel_rd[RD_W-2 -: KEY_W];
			end_b            <= sel_rd[RD_W-2-KEY_W -: KEY_W];
			a_to_b_packets   <= OUT_CW'(sel_rd[4*COUNTER_BITS-1 -: COUNTER_BITS]);
			a_to_b_bytes     <= OUT_CW'(sel_rd[3*COUNTER_BITS-1 -: COUNTER_BITS]);
			b_to_a_packets   <= OUT_CW'(sel_rd[2*COUNTER_BITS-1 -: COUNTER_BITS]);
			b_to_a_bytes     <= OUT_CW'(sel_rd[COUNTER_BITS-1 -: COUNTER_BITS]);
			table_overflowed <= sel_ovf;
		end
	end

endmodule

// File: tb/tb_bidirectional_conversation_counter_top.sv
// ----------------------------------------------------------------------------
// tb_bidirectional_conversation_counter_top
// Self-checking bench for the conversation counter: a queue-fed driver pushes
// record and read transactions, a scoreboard model tracks the three tables,
// and a monitor checks every read result against it in order.
// ----------------------------------------------------------------------------
module tb_bidirectional_conversation_counter_top;
	import bcc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS_PER_TBL = 64;
	localparam int N_RANDOM      = 1550;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int DRAIN_CYCLES  = 3 * (SLOTS_PER_TBL + 2);
	localparam int LONG_HOLD     = 1500;
	localparam int POOL_N        = 10;
	localparam logic [32:0] CNT_MAX = 33'hFFFF_FFFF;

	// one input transaction
	typedef struct {
		logic        func;
		logic [47:0] src_mac, dst_mac;
		logic        is_ipv4;
		logic [31:0] src_ip, dst_ip;
		logic        is_tcp;
		logic [15:0] src_port, dst_port, captured_length;
		logic [1:0]  table_select;
		logic [5:0]  entry_index;
	} hdr_item_t;

	// one read result
	typedef struct {
		logic        entry_valid;
		logic [47:0] end_a, end_b;
		logic [31:0] ab_pkts, ab_bytes, ba_pkts, ba_bytes;
		logic        ovf;
	} entry_view_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic out_valid;
	logic out_stall = 1'b1;
	logic        func = FUNC_RECORD;
	logic [47:0] src_mac = '0, dst_mac = '0;
	logic        is_ipv4 = 1'b0;
	logic [31:0] src_ip = '0, dst_ip = '0;
	logic        is_tcp = 1'b0;
	logic [15:0] src_port = '0, dst_port = '0, captured_length = '0;
	logic [1:0]  table_select = TBL_MAC;
	logic [5:0]  entry_index = '0;
	logic        entry_valid;
	logic [47:0] end_a, end_b;
	logic [31:0] a_to_b_packets, a_to_b_bytes, b_to_a_packets, b_to_a_bytes;
	logic        table_overflowed;

	bidirectional_conversation_counter_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .src_mac(src_mac), .dst_mac(dst_mac),
		.is_ipv4(is_ipv4), .src_ip(src_ip), .dst_ip(dst_ip),
		.is_tcp(is_tcp), .src_port(src_port), .dst_port(dst_port),
		.captured_length(captured_length),
		.table_select(table_select), .entry_index(entry_index),
		.out_valid(out_valid), .out_stall(out_stall),
		.entry_valid(entry_valid), .end_a(end_a), .end_b(end_b),
		.a_to_b_packets(a_to_b_packets), .a_to_b_bytes(a_to_b_bytes),
		.b_to_a_packets(b_to_a_packets), .b_to_a_bytes(b_to_a_bytes),
		.table_overflowed(table_overflowed)
	);

	// ------------------------------------------------------------------
	// Table shadow: keys, use bits, per-direction counters, fill, overflow
	// ------------------------------------------------------------------
	logic [47:0] conv_key_a [NUM_TBL][SLOTS_PER_TBL];
	logic [47:0] conv_key_b [NUM_TBL][SLOTS_PER_TBL];
	bit          conv_used  [NUM_TBL][SLOTS_PER_TBL];
	logic [32:0] fwd_pkts   [NUM_TBL][SLOTS_PER_TBL];
	logic [32:0] fwd_bytes  [NUM_TBL][SLOTS_PER_TBL];
	logic [32:0] rev_pkts   [NUM_TBL][SLOTS_PER_TBL];
	logic [32:0] rev_bytes  [NUM_TBL][SLOTS_PER_TBL];
	int          tbl_fill   [NUM_TBL];
	bit          tbl_ovf    [NUM_TBL];

	hdr_item_t   pending_hdrs[$];
	entry_view_t expected_entries[$];
	int          mismatches = 0;
	int          cycle_count = 0;
	int          results_seen = 0;
	bit          quiet_phase = 1'b0;

	function automatic logic [32:0] sat_inc(logic [32:0] c, logic [32:0] v);
		logic [33:0] sum;
		sum = c + v;
		return (sum > CNT_MAX) ? CNT_MAX : sum[32:0];
	endfunction

	// forward hit first, then reverse hit, then allocate or flag overflow
	function automatic void count_pair(int t, logic [47:0] a, logic [47:0] b,
			logic [15:0] len);
		for (int i = 0; i < tbl_fill[t]; i++)
			if (conv_used[t][i] && conv_key_a[t][i] == a && conv_key_b[t][i] == b) begin
				fwd_pkts[t][i]  = sat_inc(fwd_pkts[t][i], 33'd1);
				fwd_bytes[t][i] = sat_inc(fwd_bytes[t][i], {17'd0, len});
				return;
			end
		for (int i = 0; i < tbl_fill[t]; i++)
			if (conv_used[t][i] && conv_key_a[t][i] == b && conv_key_b[t][i] == a) begin
				rev_pkts[t][i]  = sat_inc(rev_pkts[t][i], 33'd1);
				rev_bytes[t][i] = sat_inc(rev_bytes[t][i], {17'd0, len});
				return;
			end
		if (tbl_fill[t] >= SLOTS_PER_TBL) begin
			tbl_ovf[t] = 1'b1;
			return;
		end
		conv_used[t][tbl_fill[t]]  = 1'b1;
		conv_key_a[t][tbl_fill[t]] = a;
		conv_key_b[t][tbl_fill[t]] = b;
		fwd_pkts[t][tbl_fill[t]]   = 33'd1;
		fwd_bytes[t][tbl_fill[t]]  = {17'd0, len};
		rev_pkts[t][tbl_fill[t]]   = '0;
		rev_bytes[t][tbl_fill[t]]  = '0;
		tbl_fill[t]++;
	endfunction

	// apply one accepted transaction; reads queue an expected entry
	function automatic void track_conversation(hdr_item_t h);
		entry_view_t e;
		int t;
		int s;
		if (h.func == FUNC_RECORD) begin
			count_pair(TBL_MAC, h.src_mac, h.dst_mac, h.captured_length);
			if (h.is_ipv4) begin
				count_pair(TBL_IP, {16'd0, h.src_ip}, {16'd0, h.dst_ip}, h.captured_length);
				if (h.is_tcp)
					count_pair(TBL_PORT, {32'd0, h.src_port}, {32'd0, h.dst_port},
						h.captured_length);
			end
			return;
		end
		e = '{default: '0};
		t = h.table_select;
		s = h.entry_index;
		if (t < NUM_TBL) begin
			e.ovf = tbl_ovf[t];
			if (s < SLOTS_PER_TBL && conv_used[t][s]) begin
				e.entry_valid = 1'b1;
				e.end_a    = conv_key_a[t][s];
				e.end_b    = conv_key_b[t][s];
				e.ab_pkts  = fwd_pkts[t][s][31:0];
				e.ab_bytes = fwd_bytes[t][s][31:0];
				e.ba_pkts  = rev_pkts[t][s][31:0];
				e.ba_bytes = rev_bytes[t][s][31:0];
			end
		end
		expected_entries.push_back(e);
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want,
			results_seen);
		mismatches++;
	endtask

	// ------------------------------------------------------------------
	// Clock, reset, watchdog
	// ------------------------------------------------------------------
	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Driver: hold the payload while stalled, random gap between transactions
	// ------------------------------------------------------------------
	int send_gap = 0;
	always @(posedge clk) begin
		hdr_item_t h;
		bit busy;
		if (arst_n) begin
			busy = in_valid;
			if (in_valid && !in_stall) begin
				track_conversation('{func, src_mac, dst_mac, is_ipv4, src_ip, dst_ip,
					is_tcp, src_port, dst_port, captured_length, table_select,
					entry_index});
				busy = 1'b0;
			end
			if (!busy) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_hdrs.size() > 0) begin
					h = pending_hdrs.pop_front();
					func <= h.func;
					src_mac <= h.src_mac;
					dst_mac <= h.dst_mac;
					is_ipv4 <= h.is_ipv4;
					src_ip <= h.src_ip;
					dst_ip <= h.dst_ip;
					is_tcp <= h.is_tcp;
					src_port <= h.src_port;
					dst_port <= h.dst_port;
					captured_length <= h.captured_length;
					table_select <= h.table_select;
					entry_index <= h.entry_index;
					in_valid <= 1'b1;
					send_gap <= quiet_phase ? 0 : $urandom_range(0, 14);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: check each accepted result, then pick the next stall pattern.
	// One long hold-off lets reads pile up behind the held result.
	// ------------------------------------------------------------------
	int  stall_left = 0;
	bit  long_hold_done = 1'b0;
	always @(posedge clk) begin
		entry_view_t w;
		int next_left;
		if (arst_n) begin
			next_left = stall_left;
			if (out_valid && !out_stall) begin
				if (expected_entries.size() == 0) begin
					report("unexpected result", 64'd0, 64'd0);
				end else begin
					w = expected_entries.pop_front();
					if (entry_valid !== w.entry_valid)
						report("entry_valid", entry_valid, w.entry_valid);
					if (end_a !== w.end_a) report("end_a", end_a, w.end_a);
					if (end_b !== w.end_b) report("end_b", end_b, w.end_b);
					if (a_to_b_packets !== w.ab_pkts)
						report("a_to_b_packets", a_to_b_packets, w.ab_pkts);
					if (a_to_b_bytes !== w.ab_bytes)
						report("a_to_b_bytes", a_to_b_bytes, w.ab_bytes);
					if (b_to_a_packets !== w.ba_pkts)
						report("b_to_a_packets", b_to_a_packets, w.ba_pkts);
					if (b_to_a_bytes !== w.ba_bytes)
						report("b_to_a_bytes", b_to_a_bytes, w.ba_bytes);
					if (table_overflowed !== w.ovf)
						report("table_overflowed", table_overflowed, w.ovf);
				end
				results_seen <= results_seen + 1;
				if (!long_hold_done && results_seen >= 30) begin
					long_hold_done <= 1'b1;
					next_left = LONG_HOLD;
				end else begin
					next_left = quiet_phase ? 0 : $urandom_range(0, 14);
				end
			end else if (next_left > 0) begin
				next_left--;
			end
			stall_left <= next_left;
			out_stall <= (next_left > 0);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	logic [47:0] mac_pool  [POOL_N];
	logic [31:0] ip_pool   [POOL_N];
	logic [15:0] port_pool [POOL_N];

	task automatic push_hdr(hdr_item_t h);
		while (pending_hdrs.size() >= 2) @(posedge clk);
		pending_hdrs.push_back(h);
	endtask

	task automatic settle();
		while (pending_hdrs.size() > 0 || in_valid) @(posedge clk);
	endtask

	function automatic hdr_item_t packet(logic [47:0] sm, logic [47:0] dm, logic v4,
			logic [31:0] si, logic [31:0] di, logic tcp, logic [15:0] sp,
			logic [15:0] dp, logic [15:0] len);
		return '{FUNC_RECORD, sm, dm, v4, si, di, tcp, sp, dp, len,
			2'($urandom), 6'($urandom)};
	endfunction

	// random unrelated fields on reads; valid tables are read only at slots already written
	function automatic hdr_item_t lookup(logic [1:0] t, logic [5:0] idx);
		hdr_item_t h;
		h = packet({$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom),
			$urandom, $urandom, 1'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom));
		h.func = FUNC_READ;
		h.table_select = t;
		h.entry_index = idx;
		return h;
	endfunction

	function automatic hdr_item_t random_read();
		int t;
		t = $urandom_range(0, 3);
		if (t == 3 || tbl_fill[t] == 0) return lookup(2'd3, 6'($urandom));
		return lookup(2'(t), 6'($urandom_range(0, tbl_fill[t] - 1)));
	endfunction

	function automatic hdr_item_t random_packet();
		hdr_item_t h;
		bit noise;
		noise = ($urandom_range(0, 99) < 12);
		h = packet({$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom_range(0, 3) != 0),
			$urandom, $urandom, 1'($urandom_range(0, 3) != 0), 16'($urandom),
			16'($urandom), 16'($urandom));
		if (!noise) begin
			h.src_mac  = mac_pool[$urandom_range(0, POOL_N - 1)];
			h.dst_mac  = mac_pool[$urandom_range(0, POOL_N - 1)];
			h.src_ip   = ip_pool[$urandom_range(0, POOL_N - 1)];
			h.dst_ip   = ip_pool[$urandom_range(0, POOL_N - 1)];
			h.src_port = port_pool[$urandom_range(0, POOL_N - 1)];
			h.dst_port = port_pool[$urandom_range(0, POOL_N - 1)];
		end
		return h;
	endfunction

	initial begin
		int drain;
		for (int t = 0; t < NUM_TBL; t++) begin
			tbl_fill[t] = 0;
			tbl_ovf[t] = 1'b0;
			for (int s = 0; s < SLOTS_PER_TBL; s++) conv_used[t][s] = 1'b0;
		end
		for (int i = 0; i < POOL_N; i++) begin
			mac_pool[i]  = {$urandom, $urandom};
			ip_pool[i]   = $urandom;
			port_pool[i] = 16'($urandom);
		end
		// address extremes sit in the pools too
		mac_pool[0] = '0;  mac_pool[1] = '1;
		ip_pool[0]  = '0;  ip_pool[1]  = '1;
		port_pool[0] = '0; port_pool[1] = '1;

		wait (arst_n);
		@(posedge clk);

		// directed: new pair, forward hit, reverse hit, self pair, header mixes
		push_hdr(packet('0, '1, 1'b1, '0, '1, 1'b1, '0, '1, 16'hFFFF));
		push_hdr(packet('0, '1, 1'b1, '0, '1, 1'b1, '0, '1, 16'h0000));
		push_hdr(packet('1, '0, 1'b1, '1, '0, 1'b1, '1, '0, 16'hFFFF));
		push_hdr(packet(48'h5, 48'h5, 1'b1, 32'h7, 32'h7, 1'b1, 16'h9, 16'h9, 16'd64));
		push_hdr(packet(48'h5, 48'h5, 1'b1, 32'h7, 32'h7, 1'b1, 16'h9, 16'h9, 16'd60));
		// TCP flag without IPv4 must leave the port table alone
		push_hdr(packet(48'hA, 48'hB, 1'b0, 32'h1, 32'h2, 1'b1, 16'h3, 16'h4, 16'd100));
		push_hdr(packet(48'hB, 48'hA, 1'b1, 32'h2, 32'h1, 1'b0, 16'h4, 16'h3, 16'd200));
		settle();
		for (int t = 0; t < NUM_TBL; t++)
			for (int s = 0; s < tbl_fill[t] && s < 3; s++) push_hdr(lookup(2'(t), 6'(s)));
		push_hdr(lookup(2'd3, '1));
		push_hdr(lookup(2'd3, '0));
		// fill the MAC table past its end with fresh pairs
		for (int i = 0; i < SLOTS_PER_TBL; i++)
			push_hdr(packet({$urandom, $urandom}, {$urandom, $urandom}, 1'b0, '0, '0,
				1'b0, '0, '0, 16'($urandom)));
		settle();
		push_hdr(lookup(TBL_MAC, 6'(SLOTS_PER_TBL - 1)));
		push_hdr(lookup(TBL_IP, 6'd0));

		// random: mostly pooled conversations, some noise, reads in between
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n % 120 == 0) quiet_phase = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 99) < 35) push_hdr(random_read());
			else push_hdr(random_packet());
		end
		quiet_phase = 1'b0;

		settle();
		while (expected_entries.size() > 0) @(posedge clk);
		drain = 0;
		while (drain < DRAIN_CYCLES) begin
			@(posedge clk);
			drain++;
		end
		if (expected_entries.size() > 0)
			report("missing results", expected_entries.size(), 64'd0);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
